/* rtl/bdq_pkg.sv */
// Shared constants, codes and widths for the bounded deque block.
package bdq_pkg;

  localparam int DEPTH = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;
  localparam int KW    = 3;
  localparam int SW    = 2;

  // operation codes carried by in_kind
  localparam logic [KW-1:0] KIND_LIST   = 3'd0;
  localparam logic [KW-1:0] KIND_PUSH_F = 3'd1;
  localparam logic [KW-1:0] KIND_PUSH_B = 3'd2;
  localparam logic [KW-1:0] KIND_POP_F  = 3'd3;
  localparam logic [KW-1:0] KIND_POP_B  = 3'd4;

  // result status codes carried by out_status
  localparam logic [SW-1:0] STAT_OK         = 2'd0;
  localparam logic [SW-1:0] STAT_OVERFLOW   = 2'd1;
  localparam logic [SW-1:0] STAT_UNDERFLOW  = 2'd2;
  localparam logic [SW-1:0] STAT_EMPTY_LIST = 2'd3;

endpackage

/* rtl/bdq_ram.sv */
// Single-port synchronous RAM with registered read data.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, or read into the output register (held while re is low)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/bounded_deque_core.sv */
// Top level of the bounded deque: ring store, head and count control, result register.
//
// A double-ended queue of up to DEPTH signed 32-bit words held in one RAM.
// Input channel: in_valid/in_stall with in_kind (list, push front, push back,
// pop front, pop back) and in_value. Result channel: out_valid/out_stall with
// out_value_res, out_status and out_last.
// A push or pop gives a single status word, which appears in the
// result register on the next cycle. Codes five to seven are taken and give
// no result.
// A listing streams the stored words front to back through the RAM read
// port, one word per cycle once the first read returns, while the receiver
// does not stall. out_last marks the back word. An empty store answers a
// listing with one word.
// New words are taken only while no listing is running and the result
// register is free or being emptied in the same cycle; otherwise in_stall is
// high. A stall on the result side holds the result register and, in turn,
// the RAM read stream and the input channel.
// Reset (rst_n low, synchronous) empties the deque: head and count go to
// zero and no result is pending. The RAM contents are not cleared.
module bounded_deque_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [bdq_pkg::KW-1:0]    in_kind,
  input  logic signed [bdq_pkg::DW-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [bdq_pkg::DW-1:0] out_value_res,
  output logic [bdq_pkg::SW-1:0]    out_status,
  output logic                      out_last
);
  import bdq_pkg::*;

  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic {S_IDLE, S_LIST} state_t;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic           pend_r, pend_nxt;
  logic           pend_last_r, pend_last_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [DW-1:0]  out_value_r, out_value_nxt;
  logic [SW-1:0]  out_status_r, out_status_nxt;
  logic           out_last_r, out_last_nxt;

  logic           out_free, in_acc;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_addr, wr_addr;
  logic [DW-1:0]  ram_rdata;
  logic [CW:0]    back_sum;
  logic [AW-1:0]  back_pos, front_pos;
  logic           empty, full;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign empty    = (count_r == '0);
  assign full     = (count_r == FULL_CNT);

  // ring positions: one before the head, and one past the back
  assign front_pos = (head_r == '0) ? LAST_POS : AW'(head_r - 1'b1);
  assign back_sum  = (CW+1)'(head_r) + (CW+1)'(count_r);
  assign back_pos  = (back_sum >= (CW+1)'(DEPTH)) ? AW'(back_sum - (CW+1)'(DEPTH))
                                                  : AW'(back_sum);

  // next state, RAM access and result word
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pend_last_nxt  = pend_last_r;
    out_valid_nxt  = out_free ? 1'b0 : out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    wr_addr        = back_pos;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = STAT_OK;
          case (in_kind)
            KIND_LIST: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY_LIST;
              end else begin
                state_nxt  = S_LIST;
                rd_ptr_nxt = head_r;
                idx_nxt    = '0;
                pend_nxt   = 1'b0;
              end
            end
            KIND_PUSH_F, KIND_PUSH_B: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = STAT_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                count_nxt = CW'(count_r + 1'b1);
                if (in_kind == KIND_PUSH_F) begin
                  wr_addr  = front_pos;
                  head_nxt = front_pos;
                end
              end
            end
            KIND_POP_F, KIND_POP_B: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_status_nxt = STAT_UNDERFLOW;
              end else begin
                count_nxt = CW'(count_r - 1'b1);
                if (in_kind == KIND_POP_F) begin
                  head_nxt = (head_r == LAST_POS) ? '0 : AW'(head_r + 1'b1);
                end
              end
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      S_LIST: begin
        // move the returned word into the result register
        if (pend_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = ram_rdata;
          out_status_nxt = STAT_OK;
          out_last_nxt   = pend_last_r;
          pend_nxt       = 1'b0;
          if (pend_last_r) begin
            state_nxt = S_IDLE;
          end
        end
        // issue the next read once the read register will be free
        if ((idx_r != count_r) && (!pend_r || out_free)) begin
          ram_re        = 1'b1;
          rd_ptr_nxt    = (rd_ptr_r == LAST_POS) ? '0 : AW'(rd_ptr_r + 1'b1);
          idx_nxt       = CW'(idx_r + 1'b1);
          pend_nxt      = 1'b1;
          pend_last_nxt = (CW'(idx_r + 1'b1) == count_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // writes happen only when idle and reads only while listing, so one port serves
  assign ram_addr = ram_re ? rd_ptr_r : wr_addr;

  bdq_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (in_value),
    .rdata (ram_rdata)
  );

  // hold control and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rd_ptr_r    <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

endmodule

/* rtl/bdq_checker.sv */
// Port-level checks for the bounded deque and the bind that attaches them.
module bdq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [bdq_pkg::DW-1:0] out_value_res,
  input logic [bdq_pkg::SW-1:0]        out_status,
  input logic                          out_last
);
  import bdq_pkg::*;

  // a stalled input word stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("input word withdrawn while stalled");

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // status words are always the final word of their item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_last)
    else $error("status word not marked last");

  // status words carry a zero value
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> (out_value_res == '0))
    else $error("status word with non-zero value");

  // no new word is taken while a non-final listing word waits
  a_list_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken during a listing");

endmodule

bind bounded_deque_core bdq_checker u_bdq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value_res (out_value_res),
  .out_status    (out_status),
  .out_last      (out_last)
);
